### rtl/gdps_pkg.sv
`default_nettype none

package gdps_pkg;

  // Number formats
  localparam int unsigned ElemW  = 16;  // A, B in Q1.15
  localparam int unsigned ScaleW = 16;  // alpha, beta in Q8.8
  localparam int unsigned CW     = 32;  // C in Q16.16
  localparam int unsigned ProdW  = 32;  // exact Q2.30 product
  localparam int unsigned AccW   = 48;  // product sum
  localparam int unsigned CfgIdxW = 2;

  // Decoupling queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALPHA = 2'd0,
    CFG_BETA  = 2'd1
  } cfg_idx_e;

  // One classified term handed from front to back
  typedef struct packed {
    logic signed [ProdW-1:0] prod;
    logic signed [CW-1:0]    c_old;
    logic                    last;
  } entry_t;

endpackage

`default_nettype wire

### rtl/gemm_dot_product_scaler_unit.sv
`default_nettype none
// GEMM dot-product scaler: C_new = beta*C_old + alpha*sum(A*B), one element at a time.
// Input channel (push/full): one A/B element pair per transaction; the transaction
// with last_term_i set also carries the old C value and closes the dot product.
// Result channel (empty/pop): one C_new/saturated result per closing transaction,
// in order, held on the ports while empty is low until popped.
// Configuration channel (cfg_valid_i/cfg_ready_o): index 0 writes alpha, index 1 beta
// (both Q8.8); other indexes are ignored. Always ready. Write only while idle.
// Throughput: one pair per cycle for non-closing terms while full is low, set by the single 16x16
// multiplier and the 48-bit accumulator. A closing term holds the back end through its four
// steps (accumulate, partial products, sum, round/clamp) while the front end and
// its 4-entry queue keep taking pairs.
// Result path: a closing pair passes the front-end product register and the queue, then
// the four back-end steps, before it shows on the result ports.
// Reset: accumulator cleared, queue and result emptied, alpha = 1.0, beta = 0.
// Receiver stall: the result register holds; the back end waits at rounding, then
// the queue fills and full rises.

module gemm_dot_product_scaler_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [gdps_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [gdps_pkg::ScaleW-1:0]        cfg_data_i,
  // Input queue side
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic signed [gdps_pkg::ElemW-1:0]  a_elem_i,
  input  wire logic signed [gdps_pkg::ElemW-1:0]  b_elem_i,
  input  wire logic signed [gdps_pkg::CW-1:0]     c_old_i,
  input  wire logic                               last_term_i,
  // Result queue side
  output logic                                    empty,
  input  wire logic                               pop,
  output logic signed [gdps_pkg::CW-1:0]          c_new_o,
  output logic                                    saturated_o
);
  import gdps_pkg::*;

  logic signed [ScaleW-1:0] alpha_q, beta_q;
  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_wdata, q_rdata;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= 16'sh0100;
      beta_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ALPHA: alpha_q <= cfg_data_i;
        CFG_BETA:  beta_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gdps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .a_elem_i    (a_elem_i),
    .b_elem_i    (b_elem_i),
    .c_old_i     (c_old_i),
    .last_term_i (last_term_i),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata),
    .q_full_i    (q_full)
  );

  gdps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  gdps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .alpha_i     (alpha_q),
    .beta_i      (beta_q),
    .q_data_i    (q_rdata),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .c_new_o     (c_new_o),
    .saturated_o (saturated_o)
  );

endmodule

`default_nettype wire

### rtl/gdps_fifo.sv
`default_nettype none

module gdps_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  gdps_pkg::entry_t     data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output gdps_pkg::entry_t     data_o,
  output logic                 empty_o
);
  import gdps_pkg::*;

  entry_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]   count_q;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  // Fill level never exceeds depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntW'(QueueDepth))
    else $error("queue fill level out of range");

  // Pointer distance agrees with fill level when the queue is not full
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != QueueCntW'(QueueDepth)) |->
      (QueuePtrW'(wr_ptr_q - rd_ptr_q) == count_q[QueuePtrW-1:0]))
    else $error("queue pointers disagree with fill level");

endmodule

`default_nettype wire

### rtl/gdps_front.sv
`default_nettype none

module gdps_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  output logic                              full_o,
  input  wire logic signed [gdps_pkg::ElemW-1:0] a_elem_i,
  input  wire logic signed [gdps_pkg::ElemW-1:0] b_elem_i,
  input  wire logic signed [gdps_pkg::CW-1:0]    c_old_i,
  input  wire logic                         last_term_i,
  output logic                              q_push_o,
  output gdps_pkg::entry_t                  q_data_o,
  input  wire logic                         q_full_i
);
  import gdps_pkg::*;

  logic   stage_valid_q;
  entry_t stage_q;
  logic   accept, drain;

  // Stage drains into the queue when there is room
  assign drain    = stage_valid_q && !q_full_i;
  assign full_o   = stage_valid_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = drain;
  assign q_data_o = stage_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (accept) begin
      stage_valid_q <= 1'b1;
    end else if (drain) begin
      stage_valid_q <= 1'b0;
    end
  end

  // Exact Q2.30 product; old C is captured with every term but used only for the closing one
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q.prod  <= a_elem_i * b_elem_i;
      stage_q.c_old <= c_old_i;
      stage_q.last  <= last_term_i;
    end
  end

endmodule

`default_nettype wire

### rtl/gdps_back.sv
`default_nettype none

module gdps_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic signed [gdps_pkg::ScaleW-1:0] alpha_i,
  input  wire logic signed [gdps_pkg::ScaleW-1:0] beta_i,
  input  gdps_pkg::entry_t                    q_data_i,
  input  wire logic                           q_empty_i,
  output logic                                q_pop_o,
  output logic                                empty_o,
  input  wire logic                           pop_i,
  output logic signed [gdps_pkg::CW-1:0]      c_new_o,
  output logic                                saturated_o
);
  import gdps_pkg::*;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_MUL,
    ST_SUM,
    ST_RND
  } state_e;

  state_e                 state_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [AccW-1:0] fin_acc_q;
  logic signed [CW-1:0]   c_q;
  logic signed [40:0]     p_lo_q;
  logic signed [39:0]     p_hi_q;
  logic signed [47:0]     p_c_q;
  logic [63:0]            t_q;
  logic                   out_valid_q;
  logic signed [CW-1:0]   c_new_q;
  logic                   sat_q;

  logic signed [AccW:0]   acc_wide;
  logic signed [AccW-1:0] acc_next;
  logic [63:0]            t_d;
  logic [63:0]            t_rnd;
  logic [41:0]            r_full;
  logic                   ovf_pos, ovf_neg, out_free;

  assign q_pop_o     = (state_q == ST_ACC) && !q_empty_i;
  assign empty_o     = !out_valid_q;
  assign c_new_o     = c_new_q;
  assign saturated_o = sat_q;
  assign out_free    = !out_valid_q || pop_i;

  // Accumulate with clipping at the 48-bit limits
  always_comb begin
    acc_wide = {acc_q[AccW-1], acc_q} + {{(AccW+1-ProdW){q_data_i.prod[ProdW-1]}}, q_data_i.prod};
    if (acc_wide[AccW] != acc_wide[AccW-1]) begin
      acc_next = acc_wide[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_next = acc_wide[AccW-1:0];
    end
  end

  // Sum of partial products at scale 2^-38
  assign t_d = {p_hi_q, 24'b0}
             + {{23{p_lo_q[40]}}, p_lo_q}
             + {{2{p_c_q[47]}}, p_c_q, 14'b0};

  // Round half up, floor shift by 22, then clamp
  assign t_rnd   = t_q + 64'd2097152;
  assign r_full  = t_rnd[63:22];
  assign ovf_pos = !r_full[41] && (|r_full[40:31]);
  assign ovf_neg = r_full[41] && !(&r_full[40:31]);

  // Control and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_RND) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && pop_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_ACC: begin
          if (q_pop_o) begin
            if (q_data_i.last) begin
              acc_q   <= '0;
              state_q <= ST_MUL;
            end else begin
              acc_q <= acc_next;
            end
          end
        end
        ST_MUL: state_q <= ST_SUM;
        ST_SUM: state_q <= ST_RND;
        ST_RND: begin
          if (out_free) begin
            state_q <= ST_ACC;
          end
        end
        default: state_q <= ST_ACC;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_data_i.last) begin
      fin_acc_q <= acc_next;
      c_q       <= q_data_i.c_old;
    end
    if (state_q == ST_MUL) begin
      p_lo_q <= alpha_i * $signed({1'b0, fin_acc_q[23:0]});
      p_hi_q <= alpha_i * $signed(fin_acc_q[47:24]);
      p_c_q  <= beta_i * c_q;
    end
    if (state_q == ST_SUM) begin
      t_q <= t_d;
    end
    if ((state_q == ST_RND) && out_free) begin
      if (ovf_pos) begin
        c_new_q <= {1'b0, {(CW-1){1'b1}}};
        sat_q   <= 1'b1;
      end else if (ovf_neg) begin
        c_new_q <= {1'b1, {(CW-1){1'b0}}};
        sat_q   <= 1'b1;
      end else begin
        c_new_q <= r_full[CW-1:0];
        sat_q   <= 1'b0;
      end
    end
  end

  // Closing term clears the accumulator
  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_data_i.last) |=> (acc_q == '0))
    else $error("accumulator not cleared after closing term");

  // A waiting result only goes when taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> (out_valid_q && $stable(c_new_q)))
    else $error("result dropped or changed while waiting");

  // Queue is not drained while scaling is in progress
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_ACC) |-> !q_pop_o)
    else $error("queue popped during scaling");

endmodule

`default_nettype wire
